@@ rtl/core/olist_pkg.sv @@
// Shared types and codes for the ordered list block.
// Request and response payloads, internal queue item, status codes.
// No dependencies.
`timescale 1ns / 1ps

package olist_pkg;

  localparam logic [1:0] KIND_APPEND = 2'd0;
  localparam logic [1:0] KIND_DELETE = 2'd1;
  localparam logic [1:0] KIND_FIND   = 2'd2;

  localparam logic [1:0] STAT_DONE      = 2'd0;
  localparam logic [1:0] STAT_NOT_FOUND = 2'd1;
  localparam logic [1:0] STAT_FULL      = 2'd2;

  localparam int unsigned POS_W = 6;
  localparam int unsigned LEN_W = 7;

  typedef enum logic [1:0] {
    OP_APPEND,
    OP_DELETE,
    OP_FIND,
    OP_NOP
  } op_e;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_SCAN,
    BK_SHIFT,
    BK_RESULT
  } back_state_e;

  typedef struct packed {
    logic [1:0]         kind;
    logic signed [31:0] value;
  } req_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [POS_W-1:0] position;
    logic [LEN_W-1:0] length;
  } rsp_t;

  typedef struct packed {
    op_e                op;
    logic signed [31:0] value;
  } item_t;

endpackage

@@ rtl/core/olist_ram.sv @@
// Generic single write port, single read port RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps

module olist_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/core/olist_front.sv @@
// Front end: accepts requests, decodes the kind into an operation and
// holds them in a two-entry queue for the back end. Uses olist_pkg.
`timescale 1ns / 1ps

module olist_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  olist_pkg::req_t in_req_i,
  output logic           item_valid_o,
  input  logic           item_pop_i,
  output olist_pkg::item_t item_o
);

  import olist_pkg::*;

  item_t      slot_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] fill_q, fill_d;
  logic       push;
  logic       pop;
  item_t      item_new;

  always_comb begin
    item_new.value = in_req_i.value;
    unique case (in_req_i.kind)
      KIND_APPEND: item_new.op = OP_APPEND;
      KIND_DELETE: item_new.op = OP_DELETE;
      KIND_FIND:   item_new.op = OP_FIND;
      default:     item_new.op = OP_NOP;
    endcase
  end

  assign in_stall_o   = (fill_q == 2'd2);
  assign item_valid_o = (fill_q != 2'd0);
  assign item_o       = slot_q[rd_ptr_q];
  assign push         = in_valid_i && !in_stall_o;
  assign pop          = item_pop_i && item_valid_o;

  always_comb begin
    wr_ptr_d = push ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? !rd_ptr_q : rd_ptr_q;
    fill_d   = fill_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= item_new;
    end
  end

endmodule

@@ rtl/core/olist_back.sv @@
// Back end: carries out queued operations on the entry RAM and drives
// the response register. Uses olist_pkg and olist_ram.
`timescale 1ns / 1ps

module olist_back #(
  parameter int unsigned DEPTH = 64
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             item_valid_i,
  output logic             item_pop_o,
  input  olist_pkg::item_t item_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output olist_pkg::rsp_t  out_rsp_o
);

  import olist_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  back_state_e        state_q, state_d;
  op_e                op_q, op_d;
  logic signed [31:0] val_q, val_d;
  logic [CW-1:0]      scan_q, scan_d;
  logic               cmp_valid_q, cmp_valid_d;
  logic [CW-1:0]      cmp_idx_q, cmp_idx_d;
  logic [AW-1:0]      pos_q, pos_d;
  logic [1:0]         st_q, st_d;
  logic [CW-1:0]      count_q, count_d;
  logic               out_valid_q, out_valid_d;
  rsp_t               out_q, out_d;

  logic               we;
  logic [AW-1:0]      waddr;
  logic [31:0]        wdata;
  logic [AW-1:0]      raddr;
  logic [31:0]        rdata;
  logic [CW-1:0]      last_idx;
  logic [AW+POS_W-1:0] pos_ext;
  logic [CW+LEN_W-1:0] len_ext;

  olist_ram #(
    .WIDTH (32),
    .DEPTH (DEPTH)
  ) u_entries (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign last_idx = count_q - CW'(1);
  assign pos_ext  = {{POS_W{1'b0}}, pos_q};
  assign len_ext  = {{LEN_W{1'b0}}, count_q};

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    val_d       = val_q;
    scan_d      = scan_q;
    cmp_valid_d = cmp_valid_q;
    cmp_idx_d   = cmp_idx_q;
    pos_d       = pos_q;
    st_d        = st_q;
    count_d     = count_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    item_pop_o  = 1'b0;
    we          = 1'b0;
    waddr       = cmp_idx_q[AW-1:0];
    wdata       = rdata;
    raddr       = scan_q[AW-1:0];

    unique case (state_q)
      BK_IDLE: begin
        if (item_valid_i) begin
          item_pop_o  = 1'b1;
          op_d        = item_i.op;
          val_d       = item_i.value;
          scan_d      = '0;
          cmp_valid_d = 1'b0;
          pos_d       = '0;
          st_d        = STAT_DONE;
          unique case (item_i.op)
            OP_APPEND: begin
              if (count_q == CW'(DEPTH)) begin
                st_d = STAT_FULL;
              end else begin
                we      = 1'b1;
                waddr   = count_q[AW-1:0];
                wdata   = item_i.value;
                pos_d   = count_q[AW-1:0];
                count_d = count_q + CW'(1);
              end
              state_d = BK_RESULT;
            end
            OP_DELETE, OP_FIND: begin
              if (count_q == '0) begin
                st_d    = STAT_NOT_FOUND;
                state_d = BK_RESULT;
              end else begin
                state_d = BK_SCAN;
              end
            end
            default: state_d = BK_RESULT;
          endcase
        end
      end
      BK_SCAN: begin
        priority if (cmp_valid_q && (rdata == val_q)) begin
          pos_d = cmp_idx_q[AW-1:0];
          if (op_q == OP_DELETE) begin
            scan_d      = cmp_idx_q + CW'(1);
            cmp_valid_d = 1'b0;
            state_d     = BK_SHIFT;
          end else begin
            state_d = BK_RESULT;
          end
        end else if (cmp_valid_q && (cmp_idx_q == last_idx)) begin
          st_d    = STAT_NOT_FOUND;
          state_d = BK_RESULT;
        end else begin
          cmp_valid_d = (scan_q < count_q);
          cmp_idx_d   = scan_q;
          if (scan_q < count_q) begin
            scan_d = scan_q + CW'(1);
          end
        end
      end
      BK_SHIFT: begin
        we = cmp_valid_q;
        if (scan_q < count_q) begin
          cmp_valid_d = 1'b1;
          cmp_idx_d   = scan_q - CW'(1);
          scan_d      = scan_q + CW'(1);
        end else begin
          cmp_valid_d = 1'b0;
          if (!cmp_valid_q) begin
            count_d = count_q - CW'(1);
            state_d = BK_RESULT;
          end
        end
      end
      BK_RESULT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d    = 1'b1;
          out_d.status   = st_q;
          out_d.position = pos_ext[POS_W-1:0];
          out_d.length   = len_ext[LEN_W-1:0];
          state_d        = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
      cmp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
      cmp_valid_q <= cmp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q      <= op_d;
    val_q     <= val_d;
    scan_q    <= scan_d;
    cmp_idx_q <= cmp_idx_d;
    pos_q     <= pos_d;
    st_q      <= st_d;
    out_q     <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

endmodule

@@ rtl/core/ordered_list_append_delete_find.sv @@
// Channel   Direction  Payload                      Handshake
// request   in         req_t  {kind, value}         in_valid_i / in_stall_o
// response  out        rsp_t  {status, position,    out_valid_o / out_stall_i
//                              length}
//
// Append and unused kinds go from idle straight to the result state in the
// back end; find and delete scan the entry RAM one entry per cycle through
// its single read port, and delete then shifts later entries down likewise.
// A two-entry queue sits between front and back; the response register
// holds a result while out_stall_i is high. Reset empties the list at once.
// Top level of the ordered list block. Uses olist_pkg, olist_front, olist_back.
`timescale 1ns / 1ps

module ordered_list_append_delete_find #(
  parameter int unsigned DEPTH = 64
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  olist_pkg::req_t in_req_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output olist_pkg::rsp_t out_rsp_o
);

  import olist_pkg::*;

  item_t item;
  logic  item_valid;
  logic  item_pop;

  olist_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_req_i     (in_req_i),
    .item_valid_o (item_valid),
    .item_pop_i   (item_pop),
    .item_o       (item)
  );

  olist_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (item_valid),
    .item_pop_o   (item_pop),
    .item_i       (item),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_rsp_o    (out_rsp_o)
  );

endmodule

@@ rtl/core/olist_checker.sv @@
// Port-level checks for the ordered list block, bound to its top level.
// Uses olist_pkg.
`timescale 1ns / 1ps

module olist_checker #(
  parameter int unsigned DEPTH = 64
) (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            in_valid_i,
  input logic            in_stall_o,
  input olist_pkg::req_t in_req_i,
  input logic            out_valid_o,
  input logic            out_stall_i,
  input olist_pkg::rsp_t out_rsp_o
);

  import olist_pkg::*;

  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i && $stable(in_req_i))
    else $error("request dropped or changed while stalled");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_rsp_o))
    else $error("response dropped or changed while stalled");

  a_miss_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_rsp_o.status != STAT_DONE) |-> out_rsp_o.position == '0)
    else $error("nonzero position on failed request");

  a_pos_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (DEPTH <= 64) |->
      (out_rsp_o.position <= out_rsp_o.length) && (out_rsp_o.length <= DEPTH))
    else $error("position or length out of range");

  a_full_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_rsp_o.status == STAT_FULL) && (DEPTH < 128) |->
      out_rsp_o.length == DEPTH)
    else $error("full reported with room left");

endmodule

bind ordered_list_append_delete_find olist_checker #(
  .DEPTH (DEPTH)
) u_olist_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_req_i    (in_req_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_rsp_o   (out_rsp_o)
);

@@ bench/testbench.sv @@
// Self-checking bench for ordered_list_append_delete_find.
// A scoreboard class predicts every response from its own copy of the list.
// Depends on olist_pkg and the block's top level.
`timescale 1ns / 1ps

module testbench;
  import olist_pkg::*;

  localparam int unsigned LIST_DEPTH = 64;
  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] VAL_MAX = 32'sh7fff_ffff;
  localparam int DRAIN_CYCLES = 2 * LIST_DEPTH + 32;
  localparam int HOLD_CYCLES = 500;

  class list_scoreboard;
    logic signed [31:0] entries[$];
    rsp_t expected_rsp[$];
    int failures = 0;

    function void note_request(req_t req);
      rsp_t rsp;
      int hit;
      rsp = '0;
      rsp.status = STAT_DONE;
      hit = -1;
      case (req.kind)
        KIND_APPEND: begin
          if (entries.size() >= LIST_DEPTH) begin
            rsp.status = STAT_FULL;
          end else begin
            rsp.position = POS_W'(entries.size());
            entries.push_back(req.value);
          end
        end
        KIND_DELETE, KIND_FIND: begin
          for (int i = 0; i < entries.size(); i++) begin
            if (hit < 0 && entries[i] == req.value) hit = i;
          end
          if (hit < 0) begin
            rsp.status = STAT_NOT_FOUND;
          end else begin
            rsp.position = POS_W'(hit);
            if (req.kind == KIND_DELETE) entries.delete(hit);
          end
        end
        default: ;
      endcase
      rsp.length = LEN_W'(entries.size());
      expected_rsp.push_back(rsp);
    endfunction

    function void check_response(rsp_t got);
      rsp_t want;
      if (expected_rsp.size() == 0) begin
        $display("%0t: response with none pending, got status %0d position %0d length %0d",
                 $time, got.status, got.position, got.length);
        failures++;
        return;
      end
      want = expected_rsp.pop_front();
      if (got.status !== want.status) begin
        $display("%0t: status expected %0d got %0d", $time, want.status, got.status);
        failures++;
      end
      if (got.position !== want.position) begin
        $display("%0t: position expected %0d got %0d", $time, want.position, got.position);
        failures++;
      end
      if (got.length !== want.length) begin
        $display("%0t: length expected %0d got %0d", $time, want.length, got.length);
        failures++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  req_t in_req_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  rsp_t out_rsp_o;

  list_scoreboard sb = new();
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  logic hold_go = 1'b0;
  int hold_left = HOLD_CYCLES;
  int requests_sent = 0;

  ordered_list_append_delete_find #(
    .DEPTH(LIST_DEPTH)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_req_i   (in_req_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_rsp_o  (out_rsp_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(negedge clk_i) begin
    if (hold_go && hold_left != 0) begin
      out_stall_i <= 1'b1;
      hold_left <= hold_left - 1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_response(out_rsp_o);
  end

  task automatic send_request(input logic [1:0] kind, input logic signed [31:0] value);
    req_t req;
    req.kind = kind;
    req.value = value;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i <= req;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_request(req);
    if (kind != KIND_UNUSED) requests_sent++;
    @(negedge clk_i);
  endtask

  task automatic wait_all_responses();
    in_valid_i <= 1'b0;
    while (sb.expected_rsp.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  function automatic logic signed [31:0] pick_value();
    int sel;
    sel = $urandom_range(9);
    if (sel < 5 && sb.entries.size() != 0)
      return sb.entries[$urandom_range(sb.entries.size() - 1)];
    if (sel < 8) return int'($urandom_range(8)) - 4;
    return $urandom;
  endfunction

  task automatic random_sequence();
    int sel;
    int roll;
    sel = $urandom_range(9);
    if (sel < 2) begin
      while (sb.entries.size() < LIST_DEPTH) send_request(KIND_APPEND, pick_value());
      repeat ($urandom_range(3, 1)) send_request(KIND_APPEND, pick_value());
      send_request(KIND_FIND, sb.entries[LIST_DEPTH - 1]);
      send_request(KIND_FIND, $urandom);
      send_request(KIND_DELETE, sb.entries[$urandom_range(LIST_DEPTH - 1)]);
    end else if (sel < 4) begin
      while (sb.entries.size() != 0) begin
        if ($urandom_range(9) < 8)
          send_request(KIND_DELETE, sb.entries[$urandom_range(sb.entries.size() - 1)]);
        else
          send_request(KIND_DELETE, $urandom);
      end
    end else begin
      repeat (20) begin
        roll = $urandom_range(99);
        if (roll < 40) send_request(KIND_APPEND, pick_value());
        else if (roll < 65) send_request(KIND_DELETE, pick_value());
        else if (roll < 93) send_request(KIND_FIND, pick_value());
        else send_request(KIND_UNUSED, $urandom);
      end
    end
  endtask

  initial begin
    #4ms;
    $display("FAILURE");
    $finish;
  end

  initial begin
    send_idle_pct = 23;
    recv_idle_pct = 85;
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    send_request(KIND_FIND, 32'sd5);
    send_request(KIND_DELETE, 32'sd5);
    send_request(KIND_UNUSED, VAL_MIN);
    send_request(KIND_APPEND, VAL_MIN);
    send_request(KIND_APPEND, VAL_MAX);
    send_request(KIND_APPEND, 32'sd0);
    send_request(KIND_APPEND, -32'sd1);
    send_request(KIND_APPEND, 32'sd1);
    send_request(KIND_APPEND, -32'sd1);
    send_request(KIND_FIND, VAL_MAX);
    send_request(KIND_FIND, -32'sd1);
    send_request(KIND_DELETE, -32'sd1);
    send_request(KIND_FIND, -32'sd1);
    send_request(KIND_FIND, 32'sd7);
    send_request(KIND_DELETE, 32'sd12345);
    send_request(KIND_UNUSED, VAL_MAX);
    send_request(KIND_DELETE, VAL_MIN);
    send_request(KIND_DELETE, -32'sd1);
    send_request(KIND_FIND, 32'sd0);
    send_request(KIND_UNUSED, -32'sd1);

    while (requests_sent < 280) random_sequence();
    wait_all_responses();

    send_idle_pct = 85;
    recv_idle_pct = 23;
    while (requests_sent < 570) random_sequence();
    wait_all_responses();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_go = 1'b1;
    repeat (12) send_request(($urandom_range(1) != 0) ? KIND_FIND : KIND_APPEND, pick_value());
    while (requests_sent < 850) random_sequence();

    wait_all_responses();
    if (sb.failures == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
